// ===== rtl/core/ggpc_pkg.sv =====
`timescale 1ns / 1ps

package ggpc_pkg;

    localparam int MAX_ORDER  = 16;
    localparam int MAX_ROWS   = MAX_ORDER - 1;
    localparam int COL_W      = 4;
    localparam int ORDER_W    = 5;
    localparam int ROW_W      = 16;
    localparam int HALF_W     = 6;
    localparam int ACC_W      = 64;
    localparam int VAL_W      = 42;
    localparam int STEP_W     = 14;
    localparam int SHIFT_W    = 4;
    localparam int STATUS_W   = 2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_ROW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_DIV = 2'd2;

    // Control word from the sequencer to the column cells and output stage
    typedef struct packed {
        logic                 clear;
        logic                 add_en;
        logic                 add_inv;
        logic [ROW_W-1:0]     add_bits;
        logic                 halve;
        logic                 mul_en;
        logic                 shift_en;
        logic                 acc_en;
        logic                 acc_neg;
        logic                 use_der;
        logic                 emit;
        logic [ORDER_W-1:0]   order;
        logic [COL_W-1:0]     col;
        logic                 last;
        logic                 bad;
        logic [SHIFT_W-1:0]   sh;
    } ggpc_ctrl_t;

    // Scale exponent g(m)-1 with g(k) = k - floor(log2(k+1))
    function automatic logic [SHIFT_W-1:0] scale_shift(input logic [COL_W-1:0] m);
        logic [COL_W:0] v;
        logic [COL_W-1:0] lg;
        v  = {1'b0, m} + 5'd1;
        lg = '0;
        for (int b = 1; b <= COL_W; b++)
        begin
            if (v[b])
            begin
                lg = COL_W'(b);
            end
        end
        return SHIFT_W'(m - lg - 4'd1);
    endfunction

endpackage

// ===== rtl/core/glynn_gray_permanent_cofactors_core.sv =====
`timescale 1ns / 1ps

// Cofactor permanents of an (n-1) x n plus/minus one matrix.
// Input channel (in_valid/in_ready): one matrix row per transaction in
// row_signs; row_final marks the last row and starts the computation.
// Rows are taken only while the block is idle.
// Output channel (out_valid/out_ready): n transactions, columns 0..n-1,
// each with the scaled cofactor permanent and a status; last_of_run on
// column n-1.
// cfg_we/cfg_data write order_in_use (n); the user is to do so only while
// the block is idle, the block itself does not enforce it. There are
// 2^(h-1) Gray steps, h = n-1 rounded down to even; each runs in the row of
// column cells as n-1 rotate/multiply steps, one shift and one add.
// Non-final rows are accepted back to back. Up to 8192 Gray steps at n = 16.
// Reset clears all control state and sets n to 16; stored rows are
// undefined until written.
// A stall on out_ready holds the result and pauses the sequencer in S_OUT.

module glynn_gray_permanent_cofactors_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [ggpc_pkg::ROW_W-1:0]             row_signs,
    input  logic                                   row_final,
    input  logic                                   cfg_we,
    input  logic [ggpc_pkg::ORDER_W-1:0]           cfg_data,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [ggpc_pkg::COL_W-1:0]             column_index,
    output logic signed [ggpc_pkg::VAL_W-1:0]      cofactor_value,
    output logic [ggpc_pkg::STATUS_W-1:0]          status,
    output logic                                   last_of_run
);
    import ggpc_pkg::*;

    ggpc_ctrl_t ctrl;
    logic out_free;
    logic out_valid_reg;
    logic [COL_W-1:0]   col_reg;
    logic signed [VAL_W-1:0] val_reg, val_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic last_reg;

    logic signed [HALF_W-1:0] t_q  [MAX_ORDER];
    logic signed [HALF_W-1:0] t_nb [MAX_ORDER];
    logic [ACC_W-1:0] acc_q  [MAX_ORDER];
    logic [ACC_W-1:0] acc_nb [MAX_ORDER];

    logic [ACC_W-1:0] low_mask;
    logic signed [ACC_W-1:0] scaled;

    assign out_free = !out_valid_reg || out_ready;

    ggpc_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .row_signs (row_signs),
        .row_final (row_final),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .out_free  (out_free),
        .ctrl      (ctrl)
    );

    // ring of active columns: cell n-1 takes its neighbor value from cell 0
    genvar gj;
    generate
        for (gj = 0; gj < MAX_ORDER; gj++)
        begin : g_cell
            if (gj == MAX_ORDER - 1)
            begin : g_end
                assign t_nb[gj]   = t_q[0];
                assign acc_nb[gj] = '0;
            end
            else
            begin : g_mid
                assign t_nb[gj]   = (ORDER_W'(gj + 1) == ctrl.order) ? t_q[0] : t_q[gj + 1];
                assign acc_nb[gj] = acc_q[gj + 1];
            end

            ggpc_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .entry_bit (ctrl.add_bits[gj]),
                .t_in      (t_nb[gj]),
                .acc_in    (acc_nb[gj]),
                .t_out     (t_q[gj]),
                .acc_out   (acc_q[gj])
            );
        end
    endgenerate

    assign low_mask = (ACC_W'(1) << ctrl.sh) - ACC_W'(1);
    assign scaled   = $signed(acc_q[0]) >>> ctrl.sh;

    always_comb
    begin
        status_next = ST_OK;
        val_next    = '0;
        if (ctrl.bad)
        begin
            status_next = ST_BAD_ROW;
        end
        else if ((acc_q[0] & low_mask) != '0)
        begin
            status_next = ST_NOT_DIV;
        end
        else if (!scaled[ACC_W-1] && (scaled[ACC_W-2:VAL_W-1] != '0))
        begin
            val_next = {1'b0, {(VAL_W-1){1'b1}}};
        end
        else if (scaled[ACC_W-1] && (scaled[ACC_W-2:VAL_W-1] != '1))
        begin
            val_next = {1'b1, {(VAL_W-1){1'b0}}};
        end
        else
        begin
            val_next = scaled[VAL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            col_reg    <= ctrl.col;
            val_reg    <= val_next;
            status_reg <= status_next;
            last_reg   <= ctrl.last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign column_index   = col_reg;
    assign cofactor_value = val_reg;
    assign status         = status_reg;
    assign last_of_run    = last_reg;

endmodule

// ===== rtl/core/ggpc_cell.sv =====
`timescale 1ns / 1ps

module ggpc_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ggpc_pkg::ggpc_ctrl_t          ctrl,
    input  logic                          entry_bit,
    input  logic signed [ggpc_pkg::HALF_W-1:0] t_in,
    input  logic [ggpc_pkg::ACC_W-1:0]    acc_in,
    output logic signed [ggpc_pkg::HALF_W-1:0] t_out,
    output logic [ggpc_pkg::ACC_W-1:0]    acc_out
);
    import ggpc_pkg::*;

    logic signed [HALF_W-1:0] t_reg, t_next;
    logic [ACC_W-1:0] v_reg, v_next;
    logic [ACC_W-1:0] d_reg, d_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [ACC_W-1:0] term;

    // wrap-around product of a wide value and a small signed half sum
    function automatic logic [ACC_W-1:0] mul_small(input logic [ACC_W-1:0] a,
                                                   input logic signed [HALF_W-1:0] t);
        logic [HALF_W-1:0] mag;
        logic [ACC_W-1:0] p;
        mag = t[HALF_W-1] ? HALF_W'(-t) : HALF_W'(t);
        p   = '0;
        for (int b = 0; b < HALF_W; b++)
        begin
            if (mag[b])
            begin
                p = p + (a << b);
            end
        end
        return t[HALF_W-1] ? ACC_W'(-p) : p;
    endfunction

    assign term = ctrl.use_der ? d_reg : v_reg;

    always_comb
    begin
        t_next   = t_reg;
        v_next   = v_reg;
        d_next   = d_reg;
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            t_next   = '0;
            acc_next = '0;
            v_next   = ACC_W'(1);
            d_next   = '0;
        end
        else
        begin
            if (ctrl.add_en)
            begin
                t_next = (ctrl.add_inv ^ entry_bit) ? t_reg - HALF_W'(1) : t_reg + HALF_W'(1);
            end
            if (ctrl.halve)
            begin
                t_next = t_reg >>> 1;
                v_next = ACC_W'(1);
                d_next = '0;
            end
            if (ctrl.shift_en)
            begin
                t_next = t_in;
            end
            if (ctrl.mul_en)
            begin
                v_next = mul_small(v_reg, t_in);
                d_next = mul_small(d_reg, t_in) + v_reg;
            end
            if (ctrl.acc_en)
            begin
                acc_next = ctrl.acc_neg ? acc_reg - term : acc_reg + term;
                v_next   = ACC_W'(1);
                d_next   = '0;
            end
            if (ctrl.emit)
            begin
                acc_next = acc_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_reg   <= '0;
            acc_reg <= '0;
            v_reg   <= ACC_W'(1);
            d_reg   <= '0;
        end
        else
        begin
            t_reg   <= t_next;
            acc_reg <= acc_next;
            v_reg   <= v_next;
            d_reg   <= d_next;
        end
    end

    assign t_out   = t_reg;
    assign acc_out = acc_reg;

endmodule

// ===== rtl/core/ggpc_seq.sv =====
`timescale 1ns / 1ps

module ggpc_seq (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ggpc_pkg::ROW_W-1:0]     row_signs,
    input  logic                           row_final,
    input  logic                           cfg_we,
    input  logic [ggpc_pkg::ORDER_W-1:0]   cfg_data,
    input  logic                           out_free,
    output ggpc_pkg::ggpc_ctrl_t           ctrl
);
    import ggpc_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CLEAR = 7'b0000010,
        S_INIT  = 7'b0000100,
        S_HALVE = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_ACCUM = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [ORDER_W-1:0] order_reg;
    logic [ORDER_W-1:0] loaded_reg, loaded_next;
    logic [ORDER_W-1:0] n_reg, n_next;
    logic               odd_reg, odd_next;
    logic [COL_W-1:0]   h_reg, h_next;
    logic [SHIFT_W-1:0] sh_reg, sh_next;
    logic [STEP_W-1:0]  lim_reg, lim_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [COL_W-1:0]   idx_reg, idx_next;
    logic [ROW_W-1:0]   neg_reg, neg_next;
    logic               bad_reg, bad_next;
    logic [ROW_W-1:0]   rows_reg [MAX_ROWS];

    logic               accept;
    logic               store;
    logic [ORDER_W-1:0] n_clamp;
    logic [COL_W-1:0]   m_clamp;
    logic [STEP_W-1:0]  step_inc;
    logic [COL_W-1:0]   flip_r;
    logic [COL_W-1:0]   row_sel;
    logic [COL_W-1:0]   n_m1;
    logic [ROW_W-1:0]   col_mask;

    assign accept  = in_valid && in_ready;
    assign store   = accept && (loaded_reg < ORDER_W'(MAX_ROWS));
    assign n_clamp = (order_reg < ORDER_W'(3)) ? ORDER_W'(3) :
                     (order_reg > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : order_reg;
    assign m_clamp = COL_W'(n_clamp - ORDER_W'(1));
    assign n_m1    = COL_W'(n_reg - ORDER_W'(1));
    assign step_inc = step_reg + STEP_W'(1);
    assign col_mask = ROW_W'(({1'b0, {ROW_W{1'b1}}} >> (ORDER_W'(ROW_W) - n_reg)));

    // row flipped by the next Gray step: one past its lowest set bit
    always_comb
    begin
        flip_r = '0;
        for (int b = STEP_W - 1; b >= 0; b--)
        begin
            if (step_inc[b])
            begin
                flip_r = COL_W'(b + 1);
            end
        end
    end

    assign row_sel = (state_reg == S_INIT) ? COL_W'(idx_reg + COL_W'(odd_reg))
                                           : COL_W'(flip_r + COL_W'(odd_reg));

    always_comb
    begin
        state_next  = state_reg;
        loaded_next = loaded_reg;
        n_next      = n_reg;
        odd_next    = odd_reg;
        h_next      = h_reg;
        sh_next     = sh_reg;
        lim_next    = lim_reg;
        step_next   = step_reg;
        idx_next    = idx_reg;
        neg_next    = neg_reg;
        bad_next    = bad_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (store)
                    begin
                        loaded_next = loaded_reg + ORDER_W'(1);
                    end
                    if (row_final)
                    begin
                        loaded_next = '0;
                        n_next      = n_clamp;
                        odd_next    = m_clamp[0];
                        h_next      = m_clamp[0] ? m_clamp - COL_W'(1) : m_clamp;
                        sh_next     = scale_shift(m_clamp);
                        state_next  = S_CLEAR;
                    end
                end
            end
            S_CLEAR:
            begin
                bad_next = odd_reg && ((rows_reg[0] & col_mask) != '0);
                lim_next = STEP_W'((15'(1) << (h_reg - COL_W'(1))) - 15'(1));
                idx_next = '0;
                state_next = bad_next ? S_OUT : S_INIT;
            end
            S_INIT:
            begin
                idx_next = idx_reg + COL_W'(1);
                if (idx_reg == h_reg - COL_W'(1))
                begin
                    state_next = S_HALVE;
                end
            end
            S_HALVE:
            begin
                step_next  = '0;
                neg_next   = '0;
                idx_next   = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                idx_next = idx_reg + COL_W'(1);
                if (idx_reg == n_m1)
                begin
                    idx_next   = '0;
                    state_next = S_ACCUM;
                end
            end
            S_ACCUM:
            begin
                if (step_reg == lim_reg)
                begin
                    idx_next   = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    step_next        = step_inc;
                    neg_next[flip_r] = ~neg_reg[flip_r];
                    state_next       = S_MUL;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    idx_next = idx_reg + COL_W'(1);
                    if (idx_reg == n_m1)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            order_reg  <= ORDER_W'(MAX_ORDER);
            loaded_reg <= '0;
            n_reg      <= ORDER_W'(MAX_ORDER);
            odd_reg    <= 1'b0;
            h_reg      <= '0;
            sh_reg     <= '0;
            lim_reg    <= '0;
            step_reg   <= '0;
            idx_reg    <= '0;
            neg_reg    <= '0;
            bad_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            if (cfg_we)
            begin
                order_reg <= cfg_data;
            end
            loaded_reg <= loaded_next;
            n_reg      <= n_next;
            odd_reg    <= odd_next;
            h_reg      <= h_next;
            sh_reg     <= sh_next;
            lim_reg    <= lim_next;
            step_reg   <= step_next;
            idx_reg    <= idx_next;
            neg_reg    <= neg_next;
            bad_reg    <= bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            rows_reg[loaded_reg[COL_W-1:0]] <= row_signs;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        ctrl          = '0;
        ctrl.clear    = (state_reg == S_CLEAR);
        ctrl.add_en   = (state_reg == S_INIT) ||
                        ((state_reg == S_ACCUM) && (step_reg != lim_reg));
        ctrl.add_inv  = (state_reg == S_ACCUM) ? ~neg_reg[flip_r] : 1'b0;
        ctrl.add_bits = rows_reg[row_sel];
        ctrl.halve    = (state_reg == S_HALVE);
        ctrl.shift_en = (state_reg == S_MUL);
        ctrl.mul_en   = (state_reg == S_MUL) && (idx_reg != n_m1);
        ctrl.acc_en   = (state_reg == S_ACCUM);
        ctrl.acc_neg  = step_reg[0];
        ctrl.use_der  = odd_reg;
        ctrl.emit     = (state_reg == S_OUT) && out_free;
        ctrl.order    = n_reg;
        ctrl.col      = idx_reg;
        ctrl.last     = (idx_reg == n_m1);
        ctrl.bad      = bad_reg;
        ctrl.sh       = sh_reg;
    end

endmodule

// ===== sim/ggpc_cofactor_checker.sv =====
`timescale 1ns / 1ps

module ggpc_cofactor_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic                                   in_ready,
    input  logic [ggpc_pkg::ROW_W-1:0]             row_signs,
    input  logic                                   row_final,
    input  logic                                   cfg_we,
    input  logic [ggpc_pkg::ORDER_W-1:0]           cfg_data,
    input  logic                                   out_valid,
    input  logic                                   out_ready,
    input  logic [ggpc_pkg::COL_W-1:0]             column_index,
    input  logic signed [ggpc_pkg::VAL_W-1:0]      cofactor_value,
    input  logic [ggpc_pkg::STATUS_W-1:0]          status,
    input  logic                                   last_of_run,
    output int                                     fail_count,
    output int                                     pending
);
    import ggpc_pkg::*;

    typedef struct {
        logic [COL_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
        logic [STATUS_W-1:0]     st;
        logic                    last;
    } cofactor_t;

    cofactor_t              cofactor_q[$];
    logic [ROW_W-1:0]       held_rows[MAX_ORDER];
    int                     held_count = 0;
    logic [ORDER_W-1:0]     order_reg = ORDER_W'(16);
    int                     mismatches = 0;
    int                     queued = 0;

    assign fail_count = mismatches;
    assign pending    = queued;

    function automatic logic [63:0] plus_minus(logic [63:0] a, logic [63:0] v, bit neg);
        return neg ? a - v : a + v;
    endfunction

    // Glynn sum over a Gray code of row signs, then scale each column's total
    function automatic void predict_cofactors();
        int          n;
        int          m;
        int          h;
        int          off;
        bit          odd;
        bit          bad;
        bit          neg;
        int          hs[MAX_ORDER];
        int          gs[MAX_ORDER];
        int          nz[MAX_ORDER];
        logic [63:0] acc[MAX_ORDER];
        logic [63:0] tv[MAX_ORDER];
        logic [63:0] pre[MAX_ORDER+1];
        logic [63:0] der[MAX_ORDER+1];
        logic [63:0] p;
        logic [63:0] suffix;
        logic [63:0] dsuffix;
        logic [63:0] total;
        logic [63:0] v;
        logic [63:0] u;
        logic [63:0] scale;
        longint      z;
        longint      val;
        longint      vmax;
        int unsigned lim;
        int unsigned t;
        int unsigned mask;
        int          r;
        int          d;
        int          sum;
        int          zeros;
        int          z0;
        int          z1;
        int          k;
        int          lg;
        int          sh;
        cofactor_t   c;
        n = int'(order_reg);
        if (n < 3) n = 3;
        if (n > MAX_ORDER) n = MAX_ORDER;
        m    = n - 1;
        odd  = m[0];
        h    = odd ? m - 1 : m;
        off  = odd ? 1 : 0;
        mask = (32'd1 << n) - 1;
        for (int j = 0; j < MAX_ORDER; j++)
        begin
            hs[j]  = 0;
            gs[j]  = 1;
            acc[j] = '0;
        end
        bad = odd && ((32'(held_rows[0]) & mask) != 0);
        if (!bad)
        begin
            for (int j = 0; j < n; j++)
            begin
                sum = 0;
                for (int i = 0; i < h; i++)
                begin
                    sum += held_rows[off+i][j] ? -1 : 1;
                end
                hs[j] = sum / 2;
            end
            lim = 32'd1 << (h - 1);
            for (int unsigned s = 0; s < lim; s++)
            begin
                if (s != 0)
                begin
                    r = 1;
                    t = s;
                    while (!t[0])
                    begin
                        t >>= 1;
                        r++;
                    end
                    d     = -gs[r];
                    gs[r] = d;
                    for (int j = 0; j < n; j++)
                    begin
                        hs[j] += held_rows[off+r][j] ? -d : d;
                    end
                end
                zeros = 0;
                z0    = -1;
                z1    = -1;
                k     = 0;
                for (int j = 0; j < n; j++)
                begin
                    tv[j] = 64'(longint'(hs[j]));
                    if (hs[j] == 0)
                    begin
                        if (zeros == 0) z0 = j;
                        else if (zeros == 1) z1 = j;
                        zeros++;
                    end
                    else
                    begin
                        nz[k] = j;
                        k++;
                    end
                end
                if (zeros > (odd ? 2 : 1)) continue;
                neg = s[0];
                if (zeros == (odd ? 2 : 1))
                begin
                    p = 64'd1;
                    for (int i = 0; i < k; i++) p = p * tv[nz[i]];
                    acc[z0] = plus_minus(acc[z0], p, neg);
                    if (odd) acc[z1] = plus_minus(acc[z1], p, neg);
                end
                else if (!odd || zeros == 1)
                begin
                    suffix = 64'd1;
                    total  = '0;
                    pre[0] = 64'd1;
                    for (int i = 0; i < k; i++) pre[i+1] = pre[i] * tv[nz[i]];
                    for (int i = k - 1; i >= 0; i--)
                    begin
                        v          = pre[i] * suffix;
                        acc[nz[i]] = plus_minus(acc[nz[i]], v, neg);
                        total      = total + v;
                        suffix     = suffix * tv[nz[i]];
                    end
                    if (odd) acc[z0] = plus_minus(acc[z0], total, neg);
                end
                else
                begin
                    // no zero column with odd rows: use the derivative form
                    suffix  = 64'd1;
                    dsuffix = '0;
                    pre[0]  = 64'd1;
                    der[0]  = '0;
                    for (int j = 0; j < n; j++)
                    begin
                        der[j+1] = der[j] * tv[j] + pre[j];
                        pre[j+1] = pre[j] * tv[j];
                    end
                    for (int j = n - 1; j >= 0; j--)
                    begin
                        v       = der[j] * suffix + pre[j] * dsuffix;
                        acc[j]  = plus_minus(acc[j], v, neg);
                        dsuffix = dsuffix * tv[j] + suffix;
                        suffix  = suffix * tv[j];
                    end
                end
            end
        end
        t  = m + 1;
        lg = 0;
        while (t > 1)
        begin
            t >>= 1;
            lg++;
        end
        sh    = m - lg - 1;
        scale = 64'd1 << sh;
        vmax  = (longint'(1) <<< (VAL_W - 1)) - 1;
        for (int j = 0; j < n; j++)
        begin
            c.col   = COL_W'(j);
            c.value = '0;
            c.st    = ST_OK;
            c.last  = (j == n - 1);
            if (bad)
            begin
                c.st = ST_BAD_ROW;
            end
            else
            begin
                u = acc[j];
                if ((u & (scale - 1)) != 0)
                begin
                    c.st = ST_NOT_DIV;
                end
                else
                begin
                    z   = longint'(u);
                    val = z / longint'(scale);
                    if (val > vmax) val = vmax;
                    if (val < -vmax - 1) val = -vmax - 1;
                    c.value = VAL_W'(val);
                end
            end
            cofactor_q.insert(cofactor_q.size(), c);
        end
    endfunction

    always @(posedge clk)
    begin
        cofactor_t exp_c;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                order_reg = cfg_data;
            end
            if (in_valid && in_ready)
            begin
                if (held_count < MAX_ROWS)
                begin
                    held_rows[held_count] = row_signs;
                    held_count++;
                end
                if (row_final)
                begin
                    held_count = 0;
                    predict_cofactors();
                end
            end
            if (out_valid && out_ready)
            begin
                if (cofactor_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result col=%0d value=%0d status=%0d",
                                 $realtime, column_index, cofactor_value, status);
                end
                else
                begin
                    exp_c = cofactor_q.pop_front();
                    if (column_index !== exp_c.col || cofactor_value !== exp_c.value ||
                        status !== exp_c.st || last_of_run !== exp_c.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $write("%0t: mismatch exp col=%0d value=%0d status=%0d last=%0d",
                                   $realtime, exp_c.col, exp_c.value, exp_c.st, exp_c.last);
                            $display(" got col=%0d value=%0d status=%0d last=%0d",
                                     column_index, cofactor_value, status, last_of_run);
                        end
                    end
                end
            end
            queued = cofactor_q.size();
        end
    end

endmodule

// ===== sim/tb_glynn_gray_permanent_cofactors_core.sv =====
`timescale 1ns / 1ps

module tb_glynn_gray_permanent_cofactors_core;
    import ggpc_pkg::*;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [ROW_W-1:0]           row_signs = '0;
    logic                       row_final = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [ORDER_W-1:0]         cfg_data = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [COL_W-1:0]           column_index;
    logic signed [VAL_W-1:0]    cofactor_value;
    logic [STATUS_W-1:0]        status;
    logic                       last_of_run;
    int                         fail_count;
    int                         pending;

    int  rows_sent = 0;
    bit  burst = 0;
    int  stall_pct = 20;
    int  hold_reqs = 0;
    int  hold_seen = 0;
    int  hold_cnt = 0;
    int  lull_cnt = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    glynn_gray_permanent_cofactors_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .row_signs      (row_signs),
        .row_final      (row_final),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .column_index   (column_index),
        .cofactor_value (cofactor_value),
        .status         (status),
        .last_of_run    (last_of_run)
    );

    ggpc_cofactor_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .row_signs      (row_signs),
        .row_final      (row_final),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .column_index   (column_index),
        .cofactor_value (cofactor_value),
        .status         (status),
        .last_of_run    (last_of_run),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: random stalls, rare lulls, and one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_seen != hold_reqs)
        begin
            hold_seen = hold_reqs;
            hold_cnt  = 600;
        end
        if (hold_cnt > 0)
        begin
            out_ready <= 1'b0;
            hold_cnt--;
        end
        else if (lull_cnt > 0)
        begin
            out_ready <= 1'b0;
            lull_cnt--;
        end
        else
        begin
            if ($urandom_range(0, 299) == 0 && stall_pct > 0)
                lull_cnt = $urandom_range(10, 40);
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic send_row(input logic [ROW_W-1:0] r, input logic fin);
        int  gap;
        bit  ready_seen;
        gap = burst ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        row_signs <= r;
        row_final <= fin;
        do
        begin
            @(negedge clk);
            ready_seen = in_ready;
            @(posedge clk);
        end
        while (!ready_seen);
        rows_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_order(input logic [ORDER_W-1:0] v);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Random matrix of n columns; rows sometimes repeat or negate to force zero sums
    task automatic send_matrix(input int n);
        int               count;
        logic [ROW_W-1:0] r;
        logic [ROW_W-1:0] prev;
        logic [ROW_W-1:0] mask;
        burst     = ($urandom_range(0, 3) == 0);
        stall_pct = burst ? 0 : $urandom_range(0, 60);
        mask  = ROW_W'((32'd1 << n) - 1);
        count = n - 1;
        if ($urandom_range(0, 9) == 0) count += $urandom_range(1, 18 - n);
        prev = '0;
        for (int i = 0; i < count; i++)
        begin
            r = ROW_W'($urandom_range(0, 65535));
            if (i == 0 && n[0] == 1'b0 && $urandom_range(0, 9) != 0)
                r = r & ~mask;
            else if (i > 0 && $urandom_range(0, 9) < 3)
                r = $urandom_range(0, 1) ? prev : ~prev;
            prev = r;
            send_row(r, i == count - 1);
        end
    endtask

    initial
    begin
        int n;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Order below range clamps to three
        set_order(5'd0);
        send_row(16'h0000, 1'b0);
        send_row(16'hFFFF, 1'b1);
        // Odd row count: good first row, then a first row with a minus one
        set_order(5'd4);
        send_row(16'h0000, 1'b0);
        send_row(16'hFFFF, 1'b0);
        send_row(16'h0000, 1'b1);
        send_row(16'h0001, 1'b0);
        send_row(16'h00F0, 1'b0);
        send_row(16'hFF0F, 1'b1);
        // Order above range clamps to sixteen; bad first row keeps it short
        set_order(5'd31);
        for (int i = 0; i < 15; i++)
            send_row(i == 0 ? 16'h8000 : ROW_W'($urandom_range(0, 65535)), i == 14);

        // Block fills while the receiver holds off; next matrix waits at the input
        set_order(5'd5);
        hold_reqs++;
        send_matrix(5);
        send_matrix(5);

        set_order(5'd15);
        send_matrix(15);
        set_order(5'd16);
        send_matrix(16);
        set_order(5'd3);
        send_matrix(3);

        while (rows_sent < 110)
        begin
            n = ($urandom_range(0, 99) < 85) ? $urandom_range(3, 10) : $urandom_range(11, 14);
            set_order(ORDER_W'(n));
            repeat ($urandom_range(1, 3)) send_matrix(n);
        end

        drain();
        repeat (50) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial
    begin
        #60_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== glynn_gray_permanent_cofactors_core.f =====
rtl/core/ggpc_pkg.sv
rtl/core/ggpc_cell.sv
rtl/core/ggpc_seq.sv
rtl/core/glynn_gray_permanent_cofactors_core.sv
sim/ggpc_cofactor_checker.sv
sim/tb_glynn_gray_permanent_cofactors_core.sv
